>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tdpg_pkg.sv
// Package: shared constants, state codes and status types of the prime generator
`timescale 1ns / 1ps

package tdpg_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CAND_W              = 32;
  localparam int COUNT_W             = 11;
  localparam int FIRST_PRIME         = 2;
  localparam logic [COUNT_W-1:0] TARGET_RESET = 11'd1024;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_START  = 5'b00100,
    ST_RUN    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_status_t;

endpackage

>>> rtl/tdpg_if.sv
// Interfaces: candidate, result and configuration channels
`timescale 1ns / 1ps

interface tdpg_cand_if import tdpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpg_res_if import tdpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_prime;
  logic [COUNT_W-1:0] prime_count;
  logic               done_res;
  modport source (output valid, output is_prime, output prime_count, output done_res,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_count, input done_res,
                  output ready);
endinterface

interface tdpg_cfg_if import tdpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_target;
  modport source (output valid, output prime_target, input ready);
  modport sink   (input valid, input prime_target, output ready);
endinterface

>>> rtl/tdpg_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module tdpg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tdpg_mod_unit.sv
// Iterative restoring remainder unit: one dividend bit per cycle
`timescale 1ns / 1ps

module tdpg_mod_unit import tdpg_pkg::*; #(
  parameter int WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output div_status_t      status
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   rem;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic [WIDTH:0]   rem_next;

  always_comb begin
    shifted  = {rem[WIDTH-1:0], dvd[WIDTH-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr};
    rem_next = diff[WIDTH+1] ? shifted : diff[WIDTH:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

>>> rtl/trial_division_prime_generator_unit.sv
// Top level: trial-division prime generator with prime table and shared remainder unit
// Sequence: once the target is reached a taken candidate goes straight to FINISH; else
//   it steps LOAD, START and RUN per stored prime tried and ends in FINISH on a divisor or after an append.
// Throughput: one candidate at a time, taken again once its result is registered, which
//   waits while an earlier result is unaccepted; the serial remainder unit sets it.
// Reset: synchronous, active high; table holds only 2, count 1, target 1024.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trial_division_prime_generator_unit import tdpg_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic  clk,
  input  logic  rst,
  tdpg_cand_if.sink   cand,
  tdpg_res_if.source  res,
  tdpg_cfg_if.sink    cfg
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int EXT_W  = 64;

  state_t                  state;
  logic [COUNT_W-1:0]      prime_target;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;
  logic [VALUE_WIDTH-1:0]  cand_val;
  logic                    is_prime_r;
  logic                    done_r;
  logic                    out_valid;
  logic                    out_is_prime;
  logic [COUNT_W-1:0]      out_count;
  logic                    out_done;

  logic [EXT_W-1:0]        cand_ext;
  logic [CMP_W-1:0]        eff_target;
  logic [CMP_W-1:0]        count_wide;
  logic                    target_hit;
  logic                    cand_take;
  logic                    ram_we;
  logic [VALUE_WIDTH-1:0]  rd_data;
  logic [VALUE_WIDTH-1:0]  divisor;
  logic                    div_start;
  logic                    out_load;
  div_status_t             div_status;

  assign cand_ext   = EXT_W'(cand.candidate);
  assign count_wide = CMP_W'(count);
  assign eff_target = (CMP_W'(prime_target) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                                   : CMP_W'(prime_target);
  assign target_hit = (count_wide >= eff_target);
  assign cand.ready = (state == ST_IDLE);
  assign cand_take  = cand.valid && cand.ready;
  assign cfg.ready  = 1'b1;
  assign ram_we     = (state == ST_LOAD) && (idx == count);
  assign divisor    = (idx == '0) ? VALUE_WIDTH'(FIRST_PRIME) : rd_data;
  assign div_start  = (state == ST_START) && (divisor != '0);
  assign out_load   = (state == ST_FINISH) && (!out_valid || res.ready);

  tdpg_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (cand_val),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  tdpg_mod_unit #(
    .WIDTH (VALUE_WIDTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand_val),
    .divisor  (divisor),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_target <= TARGET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      prime_target <= cfg.prime_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.valid && res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= CNT_W'(1);
      idx       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cand_take) begin
            idx   <= '0;
            state <= target_hit ? ST_FINISH : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (idx == count) begin
            count <= count + 1'b1;
            state <= ST_FINISH;
          end else begin
            state <= ST_START;
          end
        end
        ST_START: begin
          if (divisor == '0) begin
            idx   <= idx + 1'b1;
            state <= ST_LOAD;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (div_status.done) begin
            if (div_status.zero) begin
              state <= ST_FINISH;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_LOAD;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cand_take) begin
      cand_val   <= cand_ext[VALUE_WIDTH-1:0];
      is_prime_r <= 1'b0;
      done_r     <= target_hit;
    end else if (ram_we) begin
      is_prime_r <= 1'b1;
    end
    if (out_load) begin
      out_is_prime <= is_prime_r;
      out_count    <= count_wide[COUNT_W-1:0];
      out_done     <= done_r;
    end
  end

  assign res.valid       = out_valid;
  assign res.is_prime    = out_is_prime;
  assign res.prime_count = out_count;
  assign res.done_res    = out_done;

  `ASSERT_NEXT(a_busy_after_take, cand_take, !cand.ready, "candidate taken while busy")
  `ASSERT_NOW(a_count_range, 1'b1,
              (count != '0) && (CMP_W'(count) <= CMP_W'(TABLE_DEPTH)), "count out of range")
  `ASSERT_NEXT(a_append_grows, ram_we, count == $past(count) + 1'b1, "append lost")
  `ASSERT_NOW(a_flags_exclusive, res.valid, !(res.is_prime && res.done_res),
              "prime reported after done")

endmodule

>>> tb/trial_division_prime_generator_unit_test.sv
// Testbench: prime generator checked item by item vs typed rows or own trial-division predictor
`timescale 1ns / 1ps

module trial_division_prime_generator_unit_test;
  import tdpg_pkg::*;

  localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS  = 75;
  localparam int SETTLE_CYCLES = 100;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic {ROW_CAND, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic               is_prime;
    logic [COUNT_W-1:0] prime_count;
    logic               done_res;
  } verdict_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CAND_W-1:0]  value;
    logic               typed;
    logic               want_prime;
    logic [COUNT_W-1:0] want_count;
    logic               want_done;
  } row_t;

  localparam row_t DIRECTED [27] = '{
    '{ROW_CAND, 32'd3,          1'b1, 1'b1, 11'd2, 1'b0},
    '{ROW_CAND, 32'd4,          1'b1, 1'b0, 11'd2, 1'b0},
    '{ROW_CAND, 32'd5,          1'b1, 1'b1, 11'd3, 1'b0},
    '{ROW_CAND, 32'd0,          1'b1, 1'b0, 11'd3, 1'b0},
    '{ROW_CAND, 32'd2,          1'b1, 1'b0, 11'd3, 1'b0},
    '{ROW_CAND, 32'hFFFF_FFFF,  1'b1, 1'b0, 11'd3, 1'b0},
    '{ROW_CAND, 32'hFFFF_FFFE,  1'b1, 1'b0, 11'd3, 1'b0},
    '{ROW_CAND, 32'd6,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd7,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd8,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd9,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd10,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd11,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CFG,  32'd6,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd12,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd13,         1'b1, 1'b1, 11'd6, 1'b0},
    '{ROW_CAND, 32'd14,         1'b1, 1'b0, 11'd6, 1'b1},
    '{ROW_CAND, 32'hFFFF_FFFF,  1'b1, 1'b0, 11'd6, 1'b1},
    '{ROW_CFG,  32'd0,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd15,         1'b1, 1'b0, 11'd6, 1'b1},
    '{ROW_CFG,  32'd1,          1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd15,         1'b1, 1'b0, 11'd6, 1'b1},
    '{ROW_CFG,  32'd2047,       1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd14,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd15,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd16,         1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_CAND, 32'd17,         1'b0, 1'b0, 11'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdpg_cand_if cand_if ();
  tdpg_res_if  res_if ();
  tdpg_cfg_if  cfg_if ();

  trial_division_prime_generator_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .cand (cand_if),
    .res  (res_if),
    .cfg  (cfg_if)
  );

  logic [CAND_W-1:0]  known_primes [DEPTH];
  int unsigned        known_count;
  logic [COUNT_W-1:0] target_reg;
  verdict_t           pending_verdicts [$];
  int unsigned        mismatches = 0;
  int unsigned        sent_items = 0;
  int unsigned        stall_left = 0;
  logic               steady = 1'b0;
  logic [CAND_W-1:0]  next_cand;
  verdict_t           got;
  verdict_t           oldest;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic verdict_t classify_candidate(logic [CAND_W-1:0] value);
    int unsigned limit;
    int unsigned i;
    logic        divided;
    verdict_t    v;
    limit = (target_reg > DEPTH) ? DEPTH : target_reg;
    v = '0;
    if (known_count >= limit) begin
      v.done_res = 1'b1;
    end else begin
      divided = 1'b0;
      for (i = 0; i < known_count && !divided; i++) begin
        if (known_primes[i] != 0 && value % known_primes[i] == 0) divided = 1'b1;
      end
      if (!divided) begin
        known_primes[known_count] = value;
        known_count++;
        v.is_prime = 1'b1;
      end
    end
    v.prime_count = known_count[COUNT_W-1:0];
    return v;
  endfunction

  task automatic offer_candidate(logic [CAND_W-1:0] value, logic typed, verdict_t want);
    int unsigned gap;
    verdict_t    v;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      cand_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_if.valid     <= 1'b1;
    cand_if.candidate <= value;
    do @(posedge clk); while (!cand_if.ready);
    v = classify_candidate(value);
    sent_items++;
    pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic write_target(logic [COUNT_W-1:0] value);
    cand_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.prime_target <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    target_reg = value;
  endtask

  task automatic report_fault(string what, verdict_t want, verdict_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected prime %0b count %0d done %0b, got prime %0b count %0d done %0b",
               $realtime, what, want.is_prime, want.prime_count, want.done_res,
               seen.is_prime, seen.prime_count, seen.done_res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.is_prime, res_if.prime_count, res_if.done_res};
      if (pending_verdicts.size() == 0) begin
        report_fault("result with nothing pending", '0, got);
      end else begin
        oldest = pending_verdicts.pop_front();
        if (got.is_prime !== oldest.is_prime || got.prime_count !== oldest.prime_count ||
            got.done_res !== oldest.done_res) begin
          report_fault("result mismatch", oldest, got);
        end
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!steady) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned        pick;
    int unsigned        burst;
    logic [CAND_W-1:0]  value;
    logic [COUNT_W-1:0] new_target;
    verdict_t           want;
    cand_if.valid       = 1'b0;
    cand_if.candidate   = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.prime_target = '0;
    known_primes[0] = FIRST_PRIME;
    known_count     = 1;
    target_reg      = TARGET_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_target(DIRECTED[i].value[COUNT_W-1:0]);
      end else begin
        want = {DIRECTED[i].want_prime, DIRECTED[i].want_count, DIRECTED[i].want_done};
        offer_candidate(DIRECTED[i].value, DIRECTED[i].typed, want);
      end
    end
    next_cand = 18;

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      new_target = COUNT_W'(known_count + $urandom_range(1, 10));
      else if (pick < 60) new_target = TARGET_RESET;
      else if (pick < 75) new_target = COUNT_W'($urandom_range(DEPTH + 1, 2047));
      else if (pick < 90) new_target = COUNT_W'($urandom_range(0, known_count));
      else                new_target = COUNT_W'(6);
      write_target(new_target);
      steady = ($urandom_range(0, 3) == 0);
      burst  = $urandom_range(8, 20);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          value = $urandom;
        end else if (pick < 15) begin
          value = $urandom_range(0, next_cand + 64);
        end else begin
          if (pick < 22) next_cand += $urandom_range(1, 5);
          value = next_cand;
          next_cand++;
        end
        // keep 1 out until the end: once stored it divides everything
        if (value == 1) value = 0;
        offer_candidate(value, 1'b0, '0);
      end
      steady = 1'b0;
    end

    write_target(COUNT_W'(known_count + 1));
    offer_candidate(32'd1, 1'b0, '0);
    offer_candidate(next_cand, 1'b0, '0);
    write_target(TARGET_RESET);
    offer_candidate(next_cand, 1'b0, '0);
    offer_candidate(next_cand + 1, 1'b0, '0);

    cand_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
